@@ src/lljp_pkg.sv @@
package lljp_pkg;

    // Field and register widths
    localparam int PIXEL_W    = 8;
    localparam int MODE_W     = 3;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default row store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // Register reset values
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(1024);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Prediction modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ZERO,
        MODE_ABOVE,
        MODE_LEFT,
        MODE_DIAG,
        MODE_PLANE,
        MODE_LEFT_GRAD,
        MODE_ABOVE_GRAD,
        MODE_AVERAGE
    } mode_t;

    // Neighborhood and control for one pixel
    typedef struct packed {
        mode_t              mode;
        logic               first_row;
        logic               first_col;
        logic [PIXEL_W-1:0] left;
        logic [PIXEL_W-1:0] above;
        logic [PIXEL_W-1:0] upper_left;
    } ctx_t;

    // One result item
    typedef struct packed {
        logic               eof;
        logic [PIXEL_W-1:0] residual;
    } res_t;

endpackage

@@ src/lossless_jpeg_predictor_residual.sv @@
// Channel   Direction  Signals                      Content
// s_*       in         s_tvalid s_tready s_tdata    pixel [7:0]
// m_*       out        m_tvalid m_tready m_tdata    residual [7:0]
//                      m_tlast                      end of frame
// cfg_*     in         cfg_we cfg_index cfg_data    mode, width, height registers
//
// One pixel per clock sustained while the output is not stalled; residuals are registered.
// The rate is set by the row store's single read and single write port, with the
// read address for the next pixel issued in the cycle the current one is taken.
// A two-entry output stage accepts one more pixel after the output stalls.
// Reset clears counters and neighbors and loads register defaults; the row store is not cleared.
module lossless_jpeg_predictor_residual
    import lljp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [7:0] pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // [7:0] residual
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > IMG_W_W + 1) ? CW + 1 : IMG_W_W + 1;
    localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

    mode_t                mode_reg;
    logic [IMG_W_W-1:0]   width_reg;
    logic [IMG_H_W-1:0]   height_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [IMG_H_W-1:0]   row_reg;
    logic [IMG_H_W-1:0]   row_next;
    logic [PIXEL_W-1:0]   left_reg;
    logic [PIXEL_W-1:0]   upleft_reg;
    logic                 byp_valid_reg;
    logic [PIXEL_W-1:0]   byp_data_reg;

    logic                 accept;
    logic [CMPW-1:0]      width_ext;
    logic [CMPW-1:0]      eff_w;
    logic [CMPW-1:0]      col_plus;
    logic [IMG_H_W:0]     eff_h;
    logic [IMG_H_W:0]     row_plus;
    logic                 last_col;
    logic                 last_row;
    logic [CW-1:0]        ram_raddr;
    logic [PIXEL_W-1:0]   ram_rdata;
    logic [PIXEL_W-1:0]   above;
    ctx_t                 ctx;
    res_t                 res;
    res_t                 out_res;

    assign accept = s_tvalid && s_tready;

    // Clamp width and height to their working range
    assign width_ext = CMPW'(width_reg);
    always_comb
    begin
        if (width_ext == '0)
        begin
            eff_w = CMPW'(1);
        end
        else if (width_ext > MAXW_C)
        begin
            eff_w = MAXW_C;
        end
        else
        begin
            eff_w = width_ext;
        end
    end
    assign eff_h = (height_reg == '0) ? (IMG_H_W+1)'(1) : {1'b0, height_reg};

    // Detect row and frame ends
    assign col_plus = CMPW'(col_reg) + CMPW'(1);
    assign row_plus = {1'b0, row_reg} + (IMG_H_W+1)'(1);
    assign last_col = col_plus >= eff_w;
    assign last_row = row_plus >= eff_h;
    assign col_next = last_col ? '0 : col_plus[CW-1:0];
    assign row_next = (last_col && last_row) ? '0 :
                      (last_col ? row_plus[IMG_H_W-1:0] : row_reg);

    // Row store: write this pixel, fetch the column of the next one
    assign ram_raddr = accept ? col_next : col_reg;

    lljp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Forward the pixel just written when the next fetch hits the same column
    assign above = byp_valid_reg ? byp_data_reg : ram_rdata;

    assign ctx.mode       = mode_reg;
    assign ctx.first_row  = (row_reg == '0);
    assign ctx.first_col  = (col_reg == '0);
    assign ctx.left       = left_reg;
    assign ctx.above      = above;
    assign ctx.upper_left = upleft_reg;

    lljp_predict u_predict (
        .ctx      (ctx),
        .pixel    (s_tdata),
        .residual (res.residual)
    );

    assign res.eof = last_col && last_row;

    // Hold configuration, scan position and neighbors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ZERO;
            width_reg     <= IMG_W_RESET;
            height_reg    <= IMG_H_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MODE)
            begin
                mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
            end
            if (cfg_we && cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data[IMG_W_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_HEIGHT)
            begin
                height_reg <= cfg_data[IMG_H_W-1:0];
            end
            byp_valid_reg <= accept && (col_next == col_reg);
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                left_reg   <= s_tdata;
                upleft_reg <= above;
            end
        end
    end

    // Capture the forwarded pixel
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_data_reg <= s_tdata;
        end
    end

    lljp_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.residual;
    assign m_tlast = out_res.eof;

endmodule

@@ src/lljp_ram.sv @@
module lljp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lljp_predict.sv @@
module lljp_predict
    import lljp_pkg::*;
(
    input  ctx_t               ctx,
    input  logic [PIXEL_W-1:0] pixel,
    output logic [PIXEL_W-1:0] residual
);

    logic signed [PIXEL_W+2:0] a_s;
    logic signed [PIXEL_W+2:0] b_s;
    logic signed [PIXEL_W+2:0] c_s;
    logic signed [PIXEL_W+2:0] diff_bc;
    logic signed [PIXEL_W+2:0] diff_ac;
    logic signed [PIXEL_W+2:0] half_bc;
    logic signed [PIXEL_W+2:0] half_ac;
    logic signed [PIXEL_W+2:0] avg_ab;
    logic signed [PIXEL_W+2:0] pred;

    // Widen neighbors to signed
    assign a_s = $signed({3'b000, ctx.left});
    assign b_s = $signed({3'b000, ctx.above});
    assign c_s = $signed({3'b000, ctx.upper_left});

    // Halve differences, truncating toward zero
    assign diff_bc = b_s - c_s;
    assign diff_ac = a_s - c_s;
    assign half_bc = (diff_bc + $signed({{(PIXEL_W+2){1'b0}}, diff_bc[PIXEL_W+2]})) >>> 1;
    assign half_ac = (diff_ac + $signed({{(PIXEL_W+2){1'b0}}, diff_ac[PIXEL_W+2]})) >>> 1;
    assign avg_ab  = (a_s + b_s) >>> 1;

    // Select prediction, edges of the frame first
    always_comb
    begin
        if (ctx.mode == MODE_ZERO || (ctx.first_row && ctx.first_col))
        begin
            pred = '0;
        end
        else if (ctx.first_col)
        begin
            pred = b_s;
        end
        else if (ctx.first_row)
        begin
            pred = a_s;
        end
        else
        begin
            case (ctx.mode)
                MODE_ABOVE:      pred = b_s;
                MODE_LEFT:       pred = a_s;
                MODE_DIAG:       pred = c_s;
                MODE_PLANE:      pred = a_s + b_s - c_s;
                MODE_LEFT_GRAD:  pred = a_s + half_bc;
                MODE_ABOVE_GRAD: pred = b_s + half_ac;
                MODE_AVERAGE:    pred = avg_ab;
                default:         pred = '0;
            endcase
        end
    end

    // Residual modulo 256
    assign residual = pixel - pred[PIXEL_W-1:0];

endmodule

@@ src/lljp_skid.sv @@
module lljp_skid
    import lljp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic load_out;
    logic load_skid;
    logic drain_skid;

    assign in_ready = !skid_valid_reg;

    // Route each transaction to the output register or the skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        drain_skid      = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                drain_skid      = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || out_ready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (drain_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load_out)
        begin
            out_data_reg <= in_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/lljp_checker.sv @@
module lljp_checker
    import lljp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [PIXEL_W-1:0] m_tdata,
    input logic               m_tlast
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    // Keep payload steady while stalled
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // Every accepted pixel yields a pending result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted pixel produced no result");

    // Backpressure only while a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind lossless_jpeg_predictor_residual lljp_checker u_lljp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
